// ===== hdl/bcpa_pkg.sv =====
// shared constants, types and helpers of the contiguous page allocator
package bcpa_pkg;

  localparam int NUM_PAGES = 1024;
  localparam int MAX_RUN   = 64;
  localparam int WORD_W    = 64;
  localparam int NUM_WORDS = NUM_PAGES / WORD_W;
  localparam int WAW       = $clog2(NUM_WORDS);
  localparam int BIT_AW    = $clog2(WORD_W);

  localparam int PAGE_W = 10;
  localparam int RUN_W  = 7;
  localparam int CNT_W  = 11;
  localparam int NUM_CLASSES = 3;
  localparam int CFG_COUNT   = 6;
  localparam int CFG_IDX_W   = 3;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DMA_FIRST    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DMA_LAST     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_FIRST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_LAST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_FIRST   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LAST    = 3'd5;

  localparam logic [PAGE_W-1:0] HIGH_LAST_RST = PAGE_W'(NUM_PAGES - 1);

  // mode and zone codes
  localparam logic       MODE_ALLOC   = 1'b0;
  localparam logic       MODE_RELEASE = 1'b1;
  localparam logic [1:0] ZONE_INVALID = 2'd3;

  // result status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NO_ROOM  = 2'd1;
  localparam logic [1:0] ST_BAD_ZONE = 2'd2;
  localparam logic [1:0] ST_FREE     = 2'd3;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic           we;
    logic [WAW-1:0] waddr;
    word_t          wdata;
    logic [WAW-1:0] raddr;
  } map_req_t;

  // bits of word w whose page lies in [b, e]
  function automatic word_t run_mask(input logic [WAW-1:0] w,
                                     input logic [PAGE_W-1:0] b,
                                     input logic [PAGE_W-1:0] e);
    word_t m;
    logic [PAGE_W-1:0] pg;
    m = '0;
    for (int i = 0; i < WORD_W; i++) begin
      pg = {w, BIT_AW'(i)};
      m[i] = (pg >= b) && (pg <= e);
    end
    return m;
  endfunction

endpackage

// ===== hdl/bcpa_map.sv =====
// used/free bitmap: one 64-page word per row, rows not yet written read as all used
module bcpa_map (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bcpa_pkg::map_req_t req_i,
  output bcpa_pkg::word_t    word_o
);

  bcpa_pkg::word_t mem [bcpa_pkg::NUM_WORDS];
  bcpa_pkg::word_t rd_q;
  logic [bcpa_pkg::NUM_WORDS-1:0] row_valid_q;
  logic rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rd_q <= mem[req_i.raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (req_i.we) begin
        row_valid_q[req_i.waddr] <= 1'b1;
      end
      rd_valid_q <= row_valid_q[req_i.raddr];
    end
  end

  assign word_o = rd_valid_q ? rd_q : '1;

endmodule

// ===== hdl/bitmap_contiguous_page_allocator.sv =====
// top level of the first-fit contiguous page allocator
// One word in, one word out. A release reads the page's map row, checks and clears
// the page bit, updates the count of one zone class per cycle and ends in S_DONE; a
// page already free skips the count update. A refused allocate goes straight to
// S_DONE. A search loads a map row (S_LOAD), scans from the class's first page in
// S_SCAN, back to S_LOAD at each new row, marks the run in one row or in two, and
// updates the counts; one that finds nothing goes from S_SCAN to S_DONE. Between
// reloads the scan checks one page bit a cycle against the single read port of the
// bitmap. After reset the map reads as all used without any clearing pass, so items
// are taken at once. The input is stalled while an item is in work; a finished
// result sits in the output register until taken, and the input stays stalled while
// the next result waits for that register.
module bitmap_contiguous_page_allocator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bcpa_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bcpa_pkg::PAGE_W-1:0]         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                mode_i,
  input  logic [1:0]                          zone_select_i,
  input  logic [bcpa_pkg::RUN_W-1:0]          run_length_i,
  input  logic [bcpa_pkg::PAGE_W-1:0]         page_index_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                ok_o,
  output logic [bcpa_pkg::PAGE_W-1:0]         base_page_o,
  output logic [1:0]                          status_o
);

  localparam int PW  = bcpa_pkg::PAGE_W;
  localparam int RW  = bcpa_pkg::RUN_W;
  localparam int CW  = bcpa_pkg::CNT_W;
  localparam int BA  = bcpa_pkg::BIT_AW;
  localparam int NC  = bcpa_pkg::NUM_CLASSES;

  localparam logic [bcpa_pkg::CFG_IDX_W-1:0] CFG_IDX_LIMIT =
    bcpa_pkg::CFG_IDX_W'(bcpa_pkg::CFG_COUNT);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOAD = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_MRD0 = 4'd3;
  localparam logic [3:0] S_MWR0 = 4'd4;
  localparam logic [3:0] S_MRD1 = 4'd5;
  localparam logic [3:0] S_MWR1 = 4'd6;
  localparam logic [3:0] S_RRD  = 4'd7;
  localparam logic [3:0] S_RCHK = 4'd8;
  localparam logic [3:0] S_CNT  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0]    state_q;
  logic [PW-1:0] cfg_q   [bcpa_pkg::CFG_COUNT];
  logic [CW-1:0] count_q [NC];

  logic          mode_q;
  logic [RW-1:0] run_q;
  logic [PW-1:0] page_q;
  logic [PW-1:0] hi_q;
  logic [PW:0]   p_q;
  logic [RW-1:0] cnt_q;
  logic [PW-1:0] base_q;
  logic [PW-1:0] end_q;
  logic [1:0]    k_q;
  logic          ok_q;
  logic [1:0]    status_q;

  logic          out_valid_q;
  logic          out_ok_q;
  logic [PW-1:0] out_base_q;
  logic [1:0]    out_status_q;

  // clipped class ranges
  logic [PW-1:0] cls_lo [NC];
  logic [PW-1:0] cls_hi [NC];
  logic          cls_ok [NC];

  always_comb begin
    logic [PW-1:0] last;
    for (int c = 0; c < NC; c++) begin
      last = cfg_q[2*c+1];
      cls_lo[c] = cfg_q[2*c];
      cls_hi[c] = ({1'b0, last} >= (PW+1)'(bcpa_pkg::NUM_PAGES)) ?
                  PW'(bcpa_pkg::NUM_PAGES - 1) : last;
      cls_ok[c] = cls_lo[c] <= cls_hi[c];
    end
  end

  bcpa_pkg::map_req_t map_req;
  bcpa_pkg::word_t    map_word;

  bcpa_map u_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (map_req),
    .word_o (map_word)
  );

  logic [bcpa_pkg::WAW-1:0] wb, we;
  assign wb = base_q[PW-1:BA];
  assign we = end_q[PW-1:BA];

  logic page_used;
  assign page_used = map_word[page_q[BA-1:0]];

  always_comb begin
    map_req.we    = 1'b0;
    map_req.waddr = wb;
    map_req.wdata = map_word;
    map_req.raddr = p_q[PW-1:BA];
    case (state_q)
      S_RRD, S_RCHK: map_req.raddr = page_q[PW-1:BA];
      S_MRD0: map_req.raddr = wb;
      S_MRD1: map_req.raddr = we;
      S_MWR0: begin
        map_req.we    = 1'b1;
        map_req.waddr = wb;
        map_req.wdata = map_word | bcpa_pkg::run_mask(wb, base_q, end_q);
        map_req.raddr = wb;
      end
      S_MWR1: begin
        map_req.we    = 1'b1;
        map_req.waddr = we;
        map_req.wdata = map_word | bcpa_pkg::run_mask(we, base_q, end_q);
        map_req.raddr = we;
      end
      default: ;
    endcase
    if (state_q == S_RCHK) begin
      map_req.we    = page_used;
      map_req.waddr = page_q[PW-1:BA];
      map_req.wdata = map_word & ~(bcpa_pkg::word_t'(1) << page_q[BA-1:0]);
    end
  end

  // scan step
  logic          scan_bit;
  logic [PW:0]   p_next;
  logic [RW-1:0] cnt_next;
  assign scan_bit = map_word[p_q[BA-1:0]];
  assign p_next   = p_q + 1'b1;
  assign cnt_next = cnt_q + 1'b1;

  // count update for class k: overlap of [base, end] with the class range
  logic [PW-1:0] ov_lo, ov_hi, ov_span;
  logic          ov_hit;
  logic [RW-1:0] ov_len;
  logic [CW:0]   cnt_sum;
  logic [CW-1:0] cnt_new;

  always_comb begin
    ov_lo   = (base_q > cls_lo[k_q]) ? base_q : cls_lo[k_q];
    ov_hi   = (end_q < cls_hi[k_q]) ? end_q : cls_hi[k_q];
    ov_hit  = cls_ok[k_q] && (ov_lo <= ov_hi);
    ov_span = ov_hi - ov_lo;
    ov_len  = ov_hit ? (ov_span[RW-1:0] + 1'b1) : '0;
    cnt_sum = {1'b0, count_q[k_q]} + (CW+1)'(ov_len);
    if (mode_q == bcpa_pkg::MODE_RELEASE) begin
      cnt_new = (cnt_sum > (CW+1)'(bcpa_pkg::COUNT_MAX)) ? bcpa_pkg::COUNT_MAX
                                                          : cnt_sum[CW-1:0];
    end else begin
      cnt_new = (count_q[k_q] < CW'(ov_len)) ? '0 : count_q[k_q] - CW'(ov_len);
    end
  end

  logic out_free;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = state_q != S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bcpa_pkg::CFG_COUNT; i++) begin
        cfg_q[i] <= (i == bcpa_pkg::CFG_HIGH_LAST) ? bcpa_pkg::HIGH_LAST_RST : '0;
      end
      for (int c = 0; c < NC; c++) begin
        count_q[c] <= '0;
      end
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_index_i < CFG_IDX_LIMIT)) begin
        cfg_q[cfg_index_i] <= cfg_data_i;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            mode_q   <= mode_i;
            run_q    <= run_length_i;
            page_q   <= page_index_i;
            ok_q     <= 1'b0;
            cnt_q    <= '0;
            if (mode_i == bcpa_pkg::MODE_RELEASE) begin
              status_q <= bcpa_pkg::ST_NO_ROOM;
              state_q  <= S_RRD;
            end else if (zone_select_i == bcpa_pkg::ZONE_INVALID) begin
              status_q <= bcpa_pkg::ST_BAD_ZONE;
              state_q  <= S_DONE;
            end else if (run_length_i == '0 ||
                         run_length_i > RW'(bcpa_pkg::MAX_RUN) ||
                         count_q[zone_select_i] < CW'(run_length_i) ||
                         !cls_ok[zone_select_i]) begin
              status_q <= bcpa_pkg::ST_NO_ROOM;
              state_q  <= S_DONE;
            end else begin
              status_q <= bcpa_pkg::ST_NO_ROOM;
              p_q      <= {1'b0, cls_lo[zone_select_i]};
              hi_q     <= cls_hi[zone_select_i];
              state_q  <= S_LOAD;
            end
          end
        end
        S_LOAD: state_q <= S_SCAN;
        S_SCAN: begin
          if (p_q > {1'b0, hi_q}) begin
            state_q <= S_DONE;
          end else if (!scan_bit && cnt_next == run_q) begin
            base_q  <= PW'(p_q - (PW+1)'(run_q) + 1'b1);
            end_q   <= p_q[PW-1:0];
            state_q <= S_MRD0;
          end else begin
            cnt_q <= scan_bit ? '0 : cnt_next;
            p_q   <= p_next;
            // next row of the map needs a fresh read
            if (p_next[BA-1:0] == '0) begin
              state_q <= S_LOAD;
            end
          end
        end
        S_MRD0: state_q <= S_MWR0;
        S_MWR0: begin
          k_q     <= '0;
          state_q <= (we != wb) ? S_MRD1 : S_CNT;
        end
        S_MRD1: state_q <= S_MWR1;
        S_MWR1: begin
          k_q     <= '0;
          state_q <= S_CNT;
        end
        S_RRD: state_q <= S_RCHK;
        S_RCHK: begin
          if (page_used &&
              ({1'b0, page_q} < (PW+1)'(bcpa_pkg::NUM_PAGES))) begin
            base_q  <= page_q;
            end_q   <= page_q;
            k_q     <= '0;
            state_q <= S_CNT;
          end else begin
            status_q <= bcpa_pkg::ST_FREE;
            state_q  <= S_DONE;
          end
        end
        S_CNT: begin
          count_q[k_q] <= cnt_new;
          k_q          <= k_q + 1'b1;
          if (k_q == 2'(NC - 1)) begin
            ok_q     <= 1'b1;
            status_q <= bcpa_pkg::ST_DONE;
            state_q  <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      out_ok_q     <= ok_q;
      out_status_q <= status_q;
      out_base_q   <= (ok_q && mode_q == bcpa_pkg::MODE_ALLOC) ? base_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = out_ok_q;
  assign base_page_o = out_base_q;
  assign status_o    = out_status_q;

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench of the contiguous page allocator
`timescale 1ns / 1ps

module testbench;

  localparam int PAGE_W      = bcpa_pkg::PAGE_W;
  localparam int RUN_W       = bcpa_pkg::RUN_W;
  localparam int CNT_W       = bcpa_pkg::CNT_W;
  localparam int NUM_PAGES   = bcpa_pkg::NUM_PAGES;
  localparam int NUM_CLASSES = bcpa_pkg::NUM_CLASSES;
  localparam int CFG_COUNT   = bcpa_pkg::CFG_COUNT;
  localparam int MAX_RUN     = bcpa_pkg::MAX_RUN;

  localparam logic [1:0] CLASS_DMA    = 2'd0;
  localparam logic [1:0] CLASS_NORMAL = 2'd1;
  localparam logic [1:0] CLASS_HIGH   = 2'd2;

  typedef struct packed {
    logic              mode;
    logic [1:0]        zone;
    logic [RUN_W-1:0]  run;
    logic [PAGE_W-1:0] page;
  } alloc_word_t;

  typedef struct packed {
    logic              ok;
    logic [PAGE_W-1:0] base;
    logic [1:0]        status;
  } alloc_result_t;

  class allocator_scoreboard;
    logic [PAGE_W-1:0] zone_bound [CFG_COUNT];
    logic [CNT_W-1:0]  zone_free [NUM_CLASSES];
    bit                page_used [NUM_PAGES];
    alloc_result_t     outcome_q [$];
    int                errors;

    function new();
      foreach (page_used[i]) page_used[i] = 1'b1;
      foreach (zone_free[i]) zone_free[i] = '0;
      foreach (zone_bound[i]) zone_bound[i] = '0;
      zone_bound[bcpa_pkg::CFG_HIGH_LAST] = bcpa_pkg::HIGH_LAST_RST;
      errors = 0;
    endfunction

    function void set_reg(int idx, logic [PAGE_W-1:0] val);
      zone_bound[idx] = val;
    endfunction

    // inclusive page range of a zone, false when empty
    function bit span(int z, output int lo, output int hi);
      lo = zone_bound[2*z];
      hi = zone_bound[2*z+1];
      if (hi > NUM_PAGES - 1) hi = NUM_PAGES - 1;
      return lo <= hi;
    endfunction

    // a page counts in every zone whose range holds it
    function void bump(int pg, bit freed);
      int lo, hi;
      for (int z = 0; z < NUM_CLASSES; z++) begin
        if (span(z, lo, hi) && pg >= lo && pg <= hi) begin
          if (freed) begin
            if (zone_free[z] != bcpa_pkg::COUNT_MAX) zone_free[z]++;
          end else if (zone_free[z] != 0) begin
            zone_free[z]--;
          end
        end
      end
    endfunction

    function alloc_result_t outcome_of(alloc_word_t w);
      alloc_result_t r;
      int lo, hi;
      bit fits;
      r.ok = 1'b0;
      r.base = '0;
      r.status = bcpa_pkg::ST_NO_ROOM;
      if (w.mode == bcpa_pkg::MODE_RELEASE) begin
        if (page_used[w.page]) begin
          page_used[w.page] = 1'b0;
          bump(w.page, 1'b1);
          r.ok = 1'b1;
          r.status = bcpa_pkg::ST_DONE;
        end else begin
          r.status = bcpa_pkg::ST_FREE;
        end
      end else if (w.zone == bcpa_pkg::ZONE_INVALID) begin
        r.status = bcpa_pkg::ST_BAD_ZONE;
      end else if (w.run >= 1 && w.run <= MAX_RUN && zone_free[w.zone] >= w.run &&
                   span(w.zone, lo, hi)) begin
        // first fit from the bottom of the zone
        for (int b = lo; b + w.run - 1 <= hi && !r.ok; b++) begin
          fits = 1'b1;
          for (int i = 0; i < w.run; i++) if (page_used[b+i]) fits = 1'b0;
          if (fits) begin
            for (int i = 0; i < w.run; i++) begin
              page_used[b+i] = 1'b1;
              bump(b + i, 1'b0);
            end
            r.ok = 1'b1;
            r.status = bcpa_pkg::ST_DONE;
            r.base = PAGE_W'(b);
          end
        end
      end
      return r;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    function void note_word(alloc_word_t w);
      outcome_q.push_back(outcome_of(w));
    endfunction

    task check_result(alloc_result_t got);
      alloc_result_t want;
      if (outcome_q.size() == 0) begin
        report($sformatf("unexpected word ok=%0d base=%0d status=%0d",
                         got.ok, got.base, got.status));
      end else begin
        want = outcome_q.pop_front();
        if (got.ok !== want.ok)
          report($sformatf("ok %0d, want %0d", got.ok, want.ok));
        if (got.base !== want.base)
          report($sformatf("base_page %0d, want %0d", got.base, want.base));
        if (got.status !== want.status)
          report($sformatf("status %0d, want %0d", got.status, want.status));
      end
    endtask
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [bcpa_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [PAGE_W-1:0]              cfg_data_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           mode_i = bcpa_pkg::MODE_ALLOC;
  logic [1:0]                     zone_select_i = CLASS_DMA;
  logic [RUN_W-1:0]               run_length_i = '0;
  logic [PAGE_W-1:0]              page_index_i = '0;
  logic                           out_stall_i = 1'b0;
  logic                           in_stall_o;
  logic                           out_valid_o;
  logic                           ok_o;
  logic [PAGE_W-1:0]              base_page_o;
  logic [1:0]                     status_o;

  allocator_scoreboard sb = new();
  bit calm = 1'b0;
  int holds_asked = 0;
  int words_sent = 0;

  always #6 clk_i = ~clk_i;

  bitmap_contiguous_page_allocator u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .zone_select_i(zone_select_i),
    .run_length_i (run_length_i),
    .page_index_i (page_index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ok_o         (ok_o),
    .base_page_o  (base_page_o),
    .status_o     (status_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result({ok_o, base_page_o, status_o});
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    int hold_left;
    int holds_done;
    hold_left = 0;
    holds_done = 0;
    forever begin
      @(posedge clk_i);
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(0, 99) < 33);
      end
    end
  end

  task automatic send_word(input logic mode, input logic [1:0] zone,
                           input logic [RUN_W-1:0] run, input logic [PAGE_W-1:0] page);
    alloc_word_t w;
    w = '{mode: mode, zone: zone, run: run, page: page};
    while (!calm && $urandom_range(0, 99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= mode;
    zone_select_i <= zone;
    run_length_i  <= run;
    page_index_i  <= page;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_word(w);
    words_sent++;
  endtask

  // wait for the result of every outstanding word, then idle before going on
  task automatic settle();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (sb.outcome_q.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    if (sb.outcome_q.size() != 0) begin
      sb.report($sformatf("%0d results never came", sb.outcome_q.size()));
      sb.outcome_q.delete();
    end
    repeat (40) @(posedge clk_i);
  endtask

  task automatic load_zones(input int df, input int dl, input int nf, input int nl,
                            input int hf, input int hl);
    logic [PAGE_W-1:0] vals [CFG_COUNT];
    vals[bcpa_pkg::CFG_DMA_FIRST]    = PAGE_W'(df);
    vals[bcpa_pkg::CFG_DMA_LAST]     = PAGE_W'(dl);
    vals[bcpa_pkg::CFG_NORMAL_FIRST] = PAGE_W'(nf);
    vals[bcpa_pkg::CFG_NORMAL_LAST]  = PAGE_W'(nl);
    vals[bcpa_pkg::CFG_HIGH_FIRST]   = PAGE_W'(hf);
    vals[bcpa_pkg::CFG_HIGH_LAST]    = PAGE_W'(hl);
    for (int i = 0; i < CFG_COUNT; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= bcpa_pkg::CFG_IDX_W'(i);
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      sb.set_reg(i, vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_item();
    int roll, z, lo, hi, len, b;
    roll = $urandom_range(0, 99);
    z = $urandom_range(0, 2);
    if (!sb.span(z, lo, hi)) begin
      lo = 0;
      hi = NUM_PAGES - 1;
    end
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_RUN) : $urandom_range(1, 8);
    if (roll < 4) begin
      send_word(bcpa_pkg::MODE_ALLOC, bcpa_pkg::ZONE_INVALID, RUN_W'($urandom),
                PAGE_W'($urandom));
    end else if (roll < 8) begin
      // length outside 1..64
      send_word(bcpa_pkg::MODE_ALLOC, 2'(z),
                $urandom_range(0, 1) ? RUN_W'(0) : RUN_W'($urandom_range(MAX_RUN + 1, 127)),
                PAGE_W'($urandom));
    end else if (roll < 12) begin
      send_word(bcpa_pkg::MODE_RELEASE, 2'($urandom), RUN_W'($urandom), PAGE_W'($urandom));
    end else if (roll < 24) begin
      // free a stretch, then ask for a run of that length
      b = $urandom_range(lo, hi);
      for (int i = 0; i < len && b + i < NUM_PAGES; i++)
        send_word(bcpa_pkg::MODE_RELEASE, 2'($urandom), RUN_W'($urandom), PAGE_W'(b + i));
      send_word(bcpa_pkg::MODE_ALLOC, 2'(z), RUN_W'(len), PAGE_W'($urandom));
    end else if (roll < 62) begin
      send_word(bcpa_pkg::MODE_RELEASE, 2'($urandom), RUN_W'($urandom),
                PAGE_W'($urandom_range(lo, hi)));
    end else begin
      send_word(bcpa_pkg::MODE_ALLOC, 2'(z), RUN_W'(len), PAGE_W'($urandom));
    end
  endtask

  initial begin
    int target, phase_end, ph;
    int bnd [6];
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset ranges: dma and normal hold page 0 only, high spans the whole map
    send_word(bcpa_pkg::MODE_ALLOC, bcpa_pkg::ZONE_INVALID, 7'd1, 10'd0);
    send_word(bcpa_pkg::MODE_ALLOC, CLASS_DMA, 7'd1, 10'd0);
    send_word(bcpa_pkg::MODE_RELEASE, CLASS_DMA, 7'd1, 10'd0);
    send_word(bcpa_pkg::MODE_RELEASE, CLASS_DMA, 7'd1, 10'd0);
    send_word(bcpa_pkg::MODE_RELEASE, bcpa_pkg::ZONE_INVALID, 7'd127, 10'd1023);
    send_word(bcpa_pkg::MODE_ALLOC, CLASS_DMA, 7'd0, 10'd0);
    send_word(bcpa_pkg::MODE_ALLOC, CLASS_HIGH, 7'd65, 10'd0);
    send_word(bcpa_pkg::MODE_ALLOC, CLASS_HIGH, 7'd127, 10'd1023);
    // count is enough but the two free pages sit at opposite ends
    send_word(bcpa_pkg::MODE_ALLOC, CLASS_HIGH, 7'd2, 10'd0);
    send_word(bcpa_pkg::MODE_ALLOC, CLASS_DMA, 7'd1, 10'd1023);
    send_word(bcpa_pkg::MODE_ALLOC, CLASS_NORMAL, 7'd1, 10'd0);
    send_word(bcpa_pkg::MODE_RELEASE, CLASS_HIGH, 7'd1, 10'd1022);
    send_word(bcpa_pkg::MODE_ALLOC, CLASS_HIGH, 7'd2, 10'd0);
    send_word(bcpa_pkg::MODE_RELEASE, CLASS_DMA, 7'd1, 10'd2);
    settle();
    // page 2 is free but was never counted in dma: dma count stays at zero
    load_zones(0, 3, 0, 0, 0, 1023);
    send_word(bcpa_pkg::MODE_ALLOC, CLASS_HIGH, 7'd1, 10'd0);
    send_word(bcpa_pkg::MODE_RELEASE, CLASS_DMA, 7'd1, 10'd2);
    send_word(bcpa_pkg::MODE_ALLOC, CLASS_DMA, 7'd1, 10'd0);
    send_word(bcpa_pkg::MODE_ALLOC, CLASS_DMA, 7'd64, 10'd0);
    settle();

    target = words_sent + 1450;
    ph = 0;
    while (words_sent < target) begin
      calm = (ph == 4);
      case (ph)
        0: load_zones(0, 63, 64, 255, 256, 1023);
        1: load_zones(0, 127, 64, 191, 100, 300);
        2: load_zones(500, 20, 1023, 1023, 0, 1023);
        3: load_zones(0, 31, 0, 31, 0, 31);
        default: begin
          for (int z = 0; z < NUM_CLASSES; z++) begin
            bnd[2*z] = $urandom_range(0, NUM_PAGES - 1);
            if ($urandom_range(0, 7) == 0) bnd[2*z+1] = $urandom_range(0, bnd[2*z]);
            else bnd[2*z+1] = bnd[2*z] + $urandom_range(0, 200);
            if (bnd[2*z+1] > NUM_PAGES - 1) bnd[2*z+1] = NUM_PAGES - 1;
          end
          load_zones(bnd[0], bnd[1], bnd[2], bnd[3], bnd[4], bnd[5]);
        end
      endcase
      if (ph == 1) holds_asked++;
      phase_end = words_sent + 120;
      while (words_sent < phase_end && words_sent < target) random_item();
      settle();
      ph++;
    end

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #300_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== bitmap_contiguous_page_allocator.f =====
hdl/bcpa_pkg.sv
hdl/bcpa_map.sv
hdl/bitmap_contiguous_page_allocator.sv
tb/testbench.sv
